### hw/rtl/sdws_pkg.sv
// Shared types and constants for the sync/detect wait supervisor.
package sdws_pkg;

    localparam int unsigned CFG_DATA_W  = 20;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned KIND_W      = 2;
    localparam int unsigned EVENT_W     = 3;

    // Result fields that travel in tdata: everything but the event code.
    localparam int unsigned OUT_FIELDS_W = 1 + 1 + 1 + 16 + 16 + 32;
    localparam int unsigned OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef struct packed {
        logic [19:0] max_wait_ms;
        logic [1:0]  timeout_policy;
        logic [15:0] warn_threshold;
        logic [7:0]  retry_limit;
        logic [15:0] debounce_ms;
        logic [19:0] detect_limit_ms;
    } cfg_t;

    typedef struct packed {
        logic [EVENT_W-1:0] event_res;
        logic               advance;
        logic               waiting_sync;
        logic               waiting_detect;
        logic [15:0]        timeout_total;
        logic [15:0]        success_total;
        logic [31:0]        wait_time_total;
    } result_t;

endpackage

### hw/rtl/sdws_cfg_regs.sv
// Configuration register file of the wait supervisor.
module sdws_cfg_regs
    import sdws_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    output cfg_t                   cfg
);

    localparam logic [CFG_INDEX_W-1:0] REG_MAX_WAIT     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_POLICY       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WARN         = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RETRY_LIMIT  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_DETECT_LIMIT = 3'd5;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_MAX_WAIT:     cfg_next.max_wait_ms     = cfg_wdata[19:0];
                REG_POLICY:       cfg_next.timeout_policy  = cfg_wdata[1:0];
                REG_WARN:         cfg_next.warn_threshold  = cfg_wdata[15:0];
                REG_RETRY_LIMIT:  cfg_next.retry_limit     = cfg_wdata[7:0];
                REG_DEBOUNCE:     cfg_next.debounce_ms     = cfg_wdata[15:0];
                REG_DETECT_LIMIT: cfg_next.detect_limit_ms = cfg_wdata[19:0];
                default: ; // drop writes past the last register
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_wait_ms     <= 20'd5000;
            cfg_reg.timeout_policy  <= 2'd0;
            cfg_reg.warn_threshold  <= 16'd5;
            cfg_reg.retry_limit     <= 8'd3;
            cfg_reg.debounce_ms     <= 16'd50;
            cfg_reg.detect_limit_ms <= 20'd10000;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### hw/rtl/sdws_engine.sv
// Wait state, counters and the combinational per-beat update of the supervisor.
module sdws_engine
    import sdws_pkg::*;
#(
    parameter int unsigned DETECT_PINS_N = 2
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     fire,
    input  logic [KIND_W-1:0]        kind,
    input  logic                     sync_level,
    input  logic [DETECT_PINS_N-1:0] detect_levels,
    input  logic                     queue_nonempty,
    input  logic                     system_running,
    input  cfg_t                     cfg,
    output result_t                  result
);

    localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SYNC   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DETECT = 2'd2;

    localparam logic [1:0] POL_SKIP  = 2'd0;
    localparam logic [1:0] POL_PAUSE = 2'd1;
    localparam logic [1:0] POL_ABORT = 2'd2;
    localparam logic [1:0] POL_RETRY = 2'd3;

    localparam logic [EVENT_W-1:0] EV_NONE           = 3'd0;
    localparam logic [EVENT_W-1:0] EV_SYNC_OK        = 3'd1;
    localparam logic [EVENT_W-1:0] EV_DETECT_OK      = 3'd2;
    localparam logic [EVENT_W-1:0] EV_DETECT_TIMEOUT = 3'd3;
    localparam logic [EVENT_W-1:0] EV_SYNC_SKIP      = 3'd4;
    localparam logic [EVENT_W-1:0] EV_PAUSE          = 3'd5;
    localparam logic [EVENT_W-1:0] EV_ABORT          = 3'd6;
    localparam logic [EVENT_W-1:0] EV_RETRY          = 3'd7;

    logic        sync_active_reg,      sync_active_next;
    logic        detect_active_reg,    detect_active_next;
    logic        debouncing_reg,       debouncing_next;
    logic [19:0] wait_elapsed_reg,     wait_elapsed_next;
    logic [31:0] stats_elapsed_reg,    stats_elapsed_next;
    logic [19:0] detect_elapsed_reg,   detect_elapsed_next;
    logic [15:0] debounce_elapsed_reg, debounce_elapsed_next;
    logic [15:0] timeout_count_reg,    timeout_count_next;
    logic [15:0] success_count_reg,    success_count_next;
    logic [7:0]  retry_count_reg,      retry_count_next;
    logic [31:0] wait_sum_reg,         wait_sum_next;

    logic [19:0] wait_inc;
    logic [31:0] stats_inc;
    logic [19:0] detect_inc;
    logic [15:0] debounce_inc;
    logic [15:0] timeout_inc;
    logic [15:0] success_inc;
    logic [32:0] sum_wide;
    logic [16:0] warn_x2;
    logic        go;
    logic        confirmed;
    logic [EVENT_W-1:0] event_code;
    logic        adv;

    // Saturating increments of the counters; the retry count is bounded by retry_limit instead.
    assign wait_inc     = (&wait_elapsed_reg)     ? wait_elapsed_reg     : wait_elapsed_reg + 20'd1;
    assign stats_inc    = (&stats_elapsed_reg)    ? stats_elapsed_reg    : stats_elapsed_reg + 32'd1;
    assign detect_inc   = (&detect_elapsed_reg)   ? detect_elapsed_reg   : detect_elapsed_reg + 20'd1;
    assign debounce_inc = (&debounce_elapsed_reg) ? debounce_elapsed_reg
                                                  : debounce_elapsed_reg + 16'd1;
    assign timeout_inc  = (&timeout_count_reg)    ? timeout_count_reg    : timeout_count_reg + 16'd1;
    assign success_inc  = (&success_count_reg)    ? success_count_reg    : success_count_reg + 16'd1;
    assign sum_wide     = {1'b0, wait_sum_reg} + {1'b0, stats_inc};
    assign warn_x2      = {cfg.warn_threshold, 1'b0};
    assign go           = queue_nonempty & system_running;

    always_comb begin
        sync_active_next      = sync_active_reg;
        detect_active_next    = detect_active_reg;
        debouncing_next       = debouncing_reg;
        wait_elapsed_next     = wait_elapsed_reg;
        stats_elapsed_next    = stats_elapsed_reg;
        detect_elapsed_next   = detect_elapsed_reg;
        debounce_elapsed_next = debounce_elapsed_reg;
        timeout_count_next    = timeout_count_reg;
        success_count_next    = success_count_reg;
        retry_count_next      = retry_count_reg;
        wait_sum_next         = wait_sum_reg;
        event_code            = EV_NONE;
        adv                   = 1'b0;
        confirmed             = 1'b0;

        case (kind)
            KIND_TICK: begin
                if (sync_active_reg) begin
                    // Sync wait takes the tick alone.
                    wait_elapsed_next  = wait_inc;
                    stats_elapsed_next = stats_inc;
                    if (sync_level) begin
                        sync_active_next   = 1'b0;
                        success_count_next = success_inc;
                        wait_sum_next      = sum_wide[32] ? '1 : sum_wide[31:0];
                        if (timeout_count_reg != 16'd0) begin
                            retry_count_next = 8'd0;
                        end
                        event_code = EV_SYNC_OK;
                        adv        = go;
                    end else if (wait_inc > cfg.max_wait_ms) begin
                        timeout_count_next = timeout_inc;
                        case (cfg.timeout_policy)
                            POL_SKIP: begin
                                sync_active_next = 1'b0;
                                if ({1'b0, timeout_inc} >= warn_x2) begin
                                    event_code = EV_PAUSE;
                                end else begin
                                    event_code = EV_SYNC_SKIP;
                                    adv        = go;
                                end
                            end
                            POL_PAUSE: begin
                                sync_active_next = 1'b0;
                                event_code       = EV_PAUSE;
                            end
                            POL_ABORT: begin
                                sync_active_next = 1'b0;
                                event_code       = EV_ABORT;
                            end
                            POL_RETRY: begin
                                if (retry_count_reg < cfg.retry_limit) begin
                                    retry_count_next  = retry_count_reg + 8'd1;
                                    wait_elapsed_next = 20'd0;
                                    event_code        = EV_RETRY;
                                end else begin
                                    retry_count_next = 8'd0;
                                    sync_active_next = 1'b0;
                                    event_code       = EV_PAUSE;
                                end
                            end
                            default: ;
                        endcase
                    end
                end else if (detect_active_reg) begin
                    detect_elapsed_next = detect_inc;
                    if (detect_levels == '0) begin
                        if (!debouncing_reg) begin
                            debouncing_next       = 1'b1;
                            debounce_elapsed_next = 16'd0;
                        end else begin
                            debounce_elapsed_next = debounce_inc;
                            confirmed = (debounce_inc >= cfg.debounce_ms);
                        end
                    end else begin
                        debouncing_next = 1'b0;
                    end
                    if (confirmed || (detect_inc > cfg.detect_limit_ms)) begin
                        detect_active_next    = 1'b0;
                        debouncing_next       = 1'b0;
                        detect_elapsed_next   = 20'd0;
                        debounce_elapsed_next = 16'd0;
                        event_code            = confirmed ? EV_DETECT_OK : EV_DETECT_TIMEOUT;
                        adv                   = go;
                    end
                end
            end
            KIND_SYNC: begin
                sync_active_next   = 1'b1;
                wait_elapsed_next  = 20'd0;
                stats_elapsed_next = 32'd0;
            end
            KIND_DETECT: begin
                detect_active_next    = 1'b1;
                detect_elapsed_next   = 20'd0;
                debouncing_next       = 1'b0;
                debounce_elapsed_next = 16'd0;
            end
            default: ; // unknown kind: no change
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_active_reg      <= 1'b0;
            detect_active_reg    <= 1'b0;
            debouncing_reg       <= 1'b0;
            wait_elapsed_reg     <= '0;
            stats_elapsed_reg    <= '0;
            detect_elapsed_reg   <= '0;
            debounce_elapsed_reg <= '0;
            timeout_count_reg    <= '0;
            success_count_reg    <= '0;
            retry_count_reg      <= '0;
            wait_sum_reg         <= '0;
        end else if (fire) begin
            sync_active_reg      <= sync_active_next;
            detect_active_reg    <= detect_active_next;
            debouncing_reg       <= debouncing_next;
            wait_elapsed_reg     <= wait_elapsed_next;
            stats_elapsed_reg    <= stats_elapsed_next;
            detect_elapsed_reg   <= detect_elapsed_next;
            debounce_elapsed_reg <= debounce_elapsed_next;
            timeout_count_reg    <= timeout_count_next;
            success_count_reg    <= success_count_next;
            retry_count_reg      <= retry_count_next;
            wait_sum_reg         <= wait_sum_next;
        end
    end

    always_comb begin
        result.event_res       = event_code;
        result.advance         = adv;
        result.waiting_sync    = sync_active_next;
        result.waiting_detect  = detect_active_next;
        result.timeout_total   = timeout_count_next;
        result.success_total   = success_count_next;
        result.wait_time_total = wait_sum_next;
    end

    a_sync_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && kind == KIND_SYNC) |=> (sync_active_reg && wait_elapsed_reg == 20'd0))
        else $error("sync start did not arm the wait");

    a_advance_event: assert property (@(posedge aclk) disable iff (!aresetn)
        result.advance |-> (event_code == EV_SYNC_OK || event_code == EV_DETECT_OK ||
                            event_code == EV_DETECT_TIMEOUT || event_code == EV_SYNC_SKIP))
        else $error("advance raised for an event that does not end a wait");

    a_success_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (success_count_reg >= $past(success_count_reg)))
        else $error("success count went down");

    a_debounce_in_detect: assert property (@(posedge aclk) disable iff (!aresetn)
        !detect_active_reg |-> !debouncing_reg)
        else $error("debouncing outside a detect wait");

endmodule

### hw/rtl/sync_detect_wait_supervisor_unit.sv
// Top level of the sync/detect wait supervisor: stream ports, input and result registers.
//
// The supervisor takes one beat per clock cycle, sustained while the master side is ready, on
// the slave stream and returns exactly one result beat for each. Every beat is a 1 ms tick, a
// start-sync-wait command or a start-detect command (tuser). A tick serves an active sync wait
// first (high sync pin = success, elapsed ticks above max_wait_ms = timeout handled by the
// configured policy), else an active detect wait (all detect pins low on one tick and then for
// debounce_ms more, at least one = confirmed, elapsed ticks above detect_limit_ms = timeout). A
// beat lands in the input register, the engine combinationally updates all wait state and
// counters and the result is held in the output register until the master side takes it; the
// input register refills in the same cycle the result register is loaded, so a stall on the
// master side costs no extra bubble. Configuration goes through a plain write port and is to
// be written while no beat is in flight (not enforced). After reset the block is ready at once.
module sync_detect_wait_supervisor_unit
    import sdws_pkg::*;
#(
    parameter int unsigned DETECT_PINS_N = 2
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    // tdata, low bit up: sync_level, detect_levels[DETECT_PINS_N], queue_nonempty,
    // system_running, zero fill
    input  logic [((DETECT_PINS_N + 3 + 7) / 8) * 8 - 1:0] s_tdata,
    // tuser: kind
    input  logic [KIND_W-1:0]      s_tuser,

    output logic                   m_tvalid,
    input  logic                   m_tready,
    // tdata, low bit up: advance, waiting_sync, waiting_detect, timeout_total[16],
    // success_total[16], wait_time_total[32], zero fill
    output logic [OUT_DATA_W-1:0]  m_tdata,
    // tuser: event_res
    output logic [EVENT_W-1:0]     m_tuser,

    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int unsigned IN_BITS_W = DETECT_PINS_N + 3;

    cfg_t cfg;

    logic                 in_valid_reg, in_valid_next;
    logic [KIND_W-1:0]    in_kind_reg;
    logic [IN_BITS_W-1:0] in_bits_reg;
    logic                 out_valid_reg, out_valid_next;
    result_t              out_result_reg;
    result_t              result;
    logic                 out_ready;
    logic                 fire;
    logic                 s_beat;

    // Advance the input register whenever the result register can take a beat.
    assign out_ready = !out_valid_reg || m_tready;
    assign fire      = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || fire;
    assign s_beat    = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_beat) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (fire) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: hold the beat until it is consumed.
    always_ff @(posedge aclk) begin
        if (s_beat) begin
            in_kind_reg <= s_tuser;
            in_bits_reg <= s_tdata[IN_BITS_W-1:0];
        end
        if (fire) begin
            out_result_reg <= result;
        end
    end

    sdws_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    sdws_engine #(
        .DETECT_PINS_N (DETECT_PINS_N)
    ) u_engine (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .fire           (fire),
        .kind           (in_kind_reg),
        .sync_level     (in_bits_reg[0]),
        .detect_levels  (in_bits_reg[DETECT_PINS_N:1]),
        .queue_nonempty (in_bits_reg[DETECT_PINS_N+1]),
        .system_running (in_bits_reg[DETECT_PINS_N+2]),
        .cfg            (cfg),
        .result         (result)
    );

    // Pack the result fields lowest first, zero fill to whole bytes.
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_result_reg.event_res;
    assign m_tdata  = OUT_DATA_W'({out_result_reg.wait_time_total,
                                   out_result_reg.success_total,
                                   out_result_reg.timeout_total,
                                   out_result_reg.waiting_detect,
                                   out_result_reg.waiting_sync,
                                   out_result_reg.advance});

endmodule

### test/sync_detect_wait_supervisor_unit_test.sv
// Self-checking testbench for the sync/detect wait supervisor: directed table, then random waits.
module sync_detect_wait_supervisor_unit_test;
    import sdws_pkg::*;

    localparam int unsigned PINS      = 2;
    localparam int unsigned S_DATA_W  = ((PINS + 3 + 7) / 8) * 8;
    // Ticks run under the widest sync limit before the pin goes high.
    localparam int unsigned WIDE_LIMIT_TICKS = 16;
    localparam int unsigned PHASE_BEATS = 150;
    localparam int unsigned PHASES      = 8;

    // Register indexes on the write port.
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_WAIT     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_POLICY       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WARN         = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RETRY        = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_DETECT_LIMIT = 3'd5;

    // Sync wait timeout policies.
    localparam logic [1:0] POL_SKIP  = 2'd0;
    localparam logic [1:0] POL_PAUSE = 2'd1;
    localparam logic [1:0] POL_ABORT = 2'd2;
    localparam logic [1:0] POL_RETRY = 2'd3;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK   = 2'd0,
        KIND_SYNC   = 2'd1,
        KIND_DETECT = 2'd2,
        KIND_BAD    = 2'd3
    } kind_e;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE           = 3'd0,
        EV_SYNC_OK        = 3'd1,
        EV_DETECT_OK      = 3'd2,
        EV_DETECT_TIMEOUT = 3'd3,
        EV_SYNC_SKIP      = 3'd4,
        EV_PAUSE          = 3'd5,
        EV_ABORT          = 3'd6,
        EV_RETRY          = 3'd7
    } event_e;

    typedef struct packed {
        kind_e            kind;
        logic             sync;
        logic [PINS-1:0]  levels;
        logic             qn;
        logic             run;
    } beat_t;

    // One line of the directed table: either a register write or a beat,
    // the beat optionally carrying a hand-typed event code and advance flag.
    typedef struct packed {
        bit                     is_write;
        logic [CFG_INDEX_W-1:0] reg_index;
        logic [CFG_DATA_W-1:0]  reg_value;
        beat_t                  beat;
        bit                     typed;
        event_e                 ev;
        bit                     adv;
    } plan_row_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata   = '0;
    logic [KIND_W-1:0]      s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic [EVENT_W-1:0]     m_tuser;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    sync_detect_wait_supervisor_unit #(
        .DETECT_PINS_N(PINS)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Predicted supervisor state and the register copy it works with.
    cfg_t        shadow;
    logic        sync_on      = 1'b0;
    logic        detect_on    = 1'b0;
    logic        settling     = 1'b0;
    logic [19:0] sync_ticks   = '0;
    logic [31:0] sync_span    = '0;
    logic [19:0] detect_ticks = '0;
    logic [15:0] settle_ticks = '0;
    logic [15:0] timeouts     = '0;
    logic [15:0] successes    = '0;
    logic [7:0]  retries      = '0;
    logic [31:0] span_sum     = '0;

    result_t     pending_results[$];
    int unsigned errors       = 0;
    int unsigned results_seen = 0;
    int unsigned beats_sent   = 0;
    bit          quiet        = 1'b0;
    logic [2:0]  stall_left   = '0;

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Hard stop: a time limit beyond the slowest legal run, with every beat under the longest idles
    // and stalls.
    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    // Work out the result of one accepted beat and advance the predicted state.
    function automatic result_t predict_wait_result(input beat_t b);
        result_t     r;
        logic        go;
        logic        confirmed;
        logic [32:0] sum;
        r         = '0;
        go        = b.qn & b.run;
        confirmed = 1'b0;
        case (b.kind)
            KIND_TICK: begin
                if (sync_on) begin
                    // A sync wait takes the tick alone; the detect wait stands still.
                    if (sync_ticks != '1) sync_ticks = sync_ticks + 1'b1;
                    if (sync_span != '1) sync_span = sync_span + 1'b1;
                    if (b.sync) begin
                        sync_on = 1'b0;
                        if (successes != '1) successes = successes + 1'b1;
                        sum      = {1'b0, span_sum} + {1'b0, sync_span};
                        span_sum = sum[32] ? '1 : sum[31:0];
                        if (timeouts != '0) retries = '0;
                        r.event_res = EV_SYNC_OK;
                        r.advance   = go;
                    end else if (sync_ticks > shadow.max_wait_ms) begin
                        if (timeouts != '1) timeouts = timeouts + 1'b1;
                        case (shadow.timeout_policy)
                            POL_SKIP: begin
                                sync_on = 1'b0;
                                // Skip turns into a pause once timeouts reach twice the threshold.
                                if ({1'b0, timeouts} >= {shadow.warn_threshold, 1'b0}) begin
                                    r.event_res = EV_PAUSE;
                                end else begin
                                    r.event_res = EV_SYNC_SKIP;
                                    r.advance   = go;
                                end
                            end
                            POL_PAUSE: begin
                                sync_on     = 1'b0;
                                r.event_res = EV_PAUSE;
                            end
                            POL_ABORT: begin
                                sync_on     = 1'b0;
                                r.event_res = EV_ABORT;
                            end
                            default: begin
                                if (retries < shadow.retry_limit) begin
                                    retries     = retries + 1'b1;
                                    sync_ticks  = '0;
                                    r.event_res = EV_RETRY;
                                end else begin
                                    retries     = '0;
                                    sync_on     = 1'b0;
                                    r.event_res = EV_PAUSE;
                                end
                            end
                        endcase
                    end
                end else if (detect_on) begin
                    if (detect_ticks != '1) detect_ticks = detect_ticks + 1'b1;
                    if (b.levels == '0) begin
                        // First quiet tick only arms the debounce; later ones count it up.
                        if (!settling) begin
                            settling     = 1'b1;
                            settle_ticks = '0;
                        end else begin
                            if (settle_ticks != '1) settle_ticks = settle_ticks + 1'b1;
                            confirmed = (settle_ticks >= shadow.debounce_ms);
                        end
                    end else begin
                        settling = 1'b0;
                    end
                    if (confirmed || detect_ticks > shadow.detect_limit_ms) begin
                        r.event_res  = confirmed ? EV_DETECT_OK : EV_DETECT_TIMEOUT;
                        r.advance    = go;
                        detect_on    = 1'b0;
                        settling     = 1'b0;
                        detect_ticks = '0;
                        settle_ticks = '0;
                    end
                end
            end
            KIND_SYNC: begin
                sync_on    = 1'b1;
                sync_ticks = '0;
                sync_span  = '0;
            end
            KIND_DETECT: begin
                detect_on    = 1'b1;
                detect_ticks = '0;
                settling     = 1'b0;
                settle_ticks = '0;
            end
            default: ;
        endcase
        r.waiting_sync    = sync_on;
        r.waiting_detect  = detect_on;
        r.timeout_total   = timeouts;
        r.success_total   = successes;
        r.wait_time_total = span_sum;
        return r;
    endfunction

    function automatic beat_t rand_beat(input kind_e kind);
        beat_t b;
        b.kind   = kind;
        b.sync   = 1'($urandom_range(0, 1));
        b.levels = PINS'($urandom_range(0, 3));
        b.qn     = 1'($urandom_range(0, 1));
        b.run    = 1'($urandom_range(0, 1));
        return b;
    endfunction

    function automatic cfg_t random_cfg(input logic [1:0] policy);
        cfg_t c;
        c.max_wait_ms     = 20'($urandom_range(0, 12));
        c.timeout_policy  = policy;
        c.warn_threshold  = 16'($urandom_range(0, 4));
        c.retry_limit     = 8'($urandom_range(0, 4));
        c.debounce_ms     = 16'($urandom_range(0, 6));
        c.detect_limit_ms = 20'($urandom_range(0, 30));
        return c;
    endfunction

    function automatic plan_row_t beat_row(input kind_e k, input logic s, input logic [1:0] l,
                                           input logic q, input logic r, input bit typed,
                                           input event_e ev, input bit adv);
        plan_row_t p;
        p          = '0;
        p.beat     = '{kind: k, sync: s, levels: l, qn: q, run: r};
        p.typed    = typed;
        p.ev       = ev;
        p.adv      = adv;
        return p;
    endfunction

    function automatic plan_row_t write_row(input logic [CFG_INDEX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] value);
        plan_row_t p;
        p           = '0;
        p.is_write  = 1'b1;
        p.reg_index = idx;
        p.reg_value = value;
        return p;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        if (errors < 40)
            $display("mismatch on %s at result %0d: got %0d, expected %0d",
                     what, results_seen, got, want);
        errors++;
    endtask

    // Present one beat, hold it until taken, then log its expected result.
    // A typed row overrides the predicted event code and advance flag.
    task automatic send(input beat_t b, input bit typed = 1'b0, input event_e ev = EV_NONE,
                        input bit adv = 1'b0);
        result_t want;
        s_tvalid <= 1'b1;
        s_tuser  <= b.kind;
        s_tdata  <= S_DATA_W'({b.run, b.qn, b.levels, b.sync});
        do @(posedge aclk); while (!s_tready);
        want = predict_wait_result(b);
        if (typed) begin
            want.event_res = ev;
            want.advance   = adv;
        end
        pending_results.push_back(want);
        beats_sent++;
        // Drop valid now and then for a short burst.
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
    endtask

    // Stop sending and wait until every expected beat has come back.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_MAX_WAIT:     shadow.max_wait_ms     = value[19:0];
            REG_POLICY:       shadow.timeout_policy  = value[1:0];
            REG_WARN:         shadow.warn_threshold  = value[15:0];
            REG_RETRY:        shadow.retry_limit     = value[7:0];
            REG_DEBOUNCE:     shadow.debounce_ms     = value[15:0];
            REG_DETECT_LIMIT: shadow.detect_limit_ms = value[19:0];
            default: ;
        endcase
    endtask

    task automatic load_config(input cfg_t c);
        settle();
        write_reg(REG_MAX_WAIT,     CFG_DATA_W'(c.max_wait_ms));
        write_reg(REG_POLICY,       CFG_DATA_W'(c.timeout_policy));
        write_reg(REG_WARN,         CFG_DATA_W'(c.warn_threshold));
        write_reg(REG_RETRY,        CFG_DATA_W'(c.retry_limit));
        write_reg(REG_DEBOUNCE,     CFG_DATA_W'(c.debounce_ms));
        write_reg(REG_DETECT_LIMIT, CFG_DATA_W'(c.detect_limit_ms));
    endtask

    // Random traffic built from whole wait episodes with random content,
    // mixed with a share of loose beats of any kind.
    task automatic random_phase(input int unsigned beats);
        int unsigned stop_at;
        int unsigned cap;
        int unsigned odds;
        int unsigned n;
        beat_t       b;
        stop_at = beats_sent + beats;
        while (beats_sent < stop_at) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    // Sync wait: run ticks until it ends or the episode runs out.
                    send(rand_beat(KIND_SYNC));
                    odds = $urandom_range(0, 20);
                    cap  = $urandom_range(1, 40);
                    for (n = 0; n < cap && sync_on; n++) begin
                        b      = rand_beat(KIND_TICK);
                        b.sync = ($urandom_range(0, 99) < odds);
                        send(b);
                    end
                end
                4, 5, 6: begin
                    // Detect wait: mostly quiet pins with some chatter.
                    send(rand_beat(KIND_DETECT));
                    odds = $urandom_range(0, 30);
                    cap  = $urandom_range(1, 50);
                    for (n = 0; n < cap && detect_on && !sync_on; n++) begin
                        b        = rand_beat(KIND_TICK);
                        b.levels = ($urandom_range(0, 99) < odds) ? 2'($urandom_range(1, 3)) : 2'b00;
                        send(b);
                    end
                end
                7: begin
                    // Both waits at once: sync is served first, detect after it ends.
                    send(rand_beat(KIND_DETECT));
                    send(rand_beat(KIND_SYNC));
                    cap = $urandom_range(1, 60);
                    for (n = 0; n < cap && (sync_on || detect_on); n++) begin
                        b        = rand_beat(KIND_TICK);
                        b.sync   = ($urandom_range(0, 9) == 0);
                        b.levels = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(1, 3)) : 2'b00;
                        send(b);
                    end
                end
                default: begin
                    cap = $urandom_range(1, 4);
                    for (n = 0; n < cap; n++)
                        send(rand_beat(kind_e'($urandom_range(0, 3))));
                end
            endcase
        end
    endtask

    // Result side: hold off in random bursts, never while quiet.
    always @(posedge aclk) begin
        if (!aresetn || quiet) begin
            m_tready   <= 1'b1;
            stall_left <= '0;
        end else if (stall_left != '0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1'b1;
        end else if ($urandom_range(0, 7) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= 3'($urandom_range(0, 4));
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Check every result beat against the oldest expectation, field by field.
    always @(posedge aclk) begin : check_results
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result beat, event", m_tuser, 0);
            end else begin
                want = pending_results.pop_front();
                if (m_tuser != want.event_res)
                    report_mismatch("event_res", m_tuser, want.event_res);
                if (m_tdata[0] != want.advance)
                    report_mismatch("advance", m_tdata[0], want.advance);
                if (m_tdata[1] != want.waiting_sync)
                    report_mismatch("waiting_sync", m_tdata[1], want.waiting_sync);
                if (m_tdata[2] != want.waiting_detect)
                    report_mismatch("waiting_detect", m_tdata[2], want.waiting_detect);
                if (m_tdata[18:3] != want.timeout_total)
                    report_mismatch("timeout_total", m_tdata[18:3], want.timeout_total);
                if (m_tdata[34:19] != want.success_total)
                    report_mismatch("success_total", m_tdata[34:19], want.success_total);
                if (m_tdata[66:35] != want.wait_time_total)
                    report_mismatch("wait_time_total", m_tdata[66:35], want.wait_time_total);
            end
            results_seen++;
        end
    end

    initial begin : stimulus
        plan_row_t   plan[$];
        plan_row_t   row;
        beat_t       b;
        cfg_t        next_cfg;
        int unsigned phase;

        // Register copy starts at the reset values.
        shadow.max_wait_ms     = 20'd5000;
        shadow.timeout_policy  = POL_SKIP;
        shadow.warn_threshold  = 16'd5;
        shadow.retry_limit     = 8'd3;
        shadow.debounce_ms     = 16'd50;
        shadow.detect_limit_ms = 20'd10000;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table. Beats: kind, sync, detect pins, queue nonempty, running,
        // typed?, event, advance. Untyped rows rely on the predictor alone.
        // Idle block: ticks with all inputs low and high, then an unknown kind.
        plan.push_back(beat_row(KIND_TICK,   1'b0, 2'b00, 1'b0, 1'b0, 1, EV_NONE, 1'b0));
        plan.push_back(beat_row(KIND_TICK,   1'b1, 2'b11, 1'b1, 1'b1, 1, EV_NONE, 1'b0));
        plan.push_back(beat_row(KIND_BAD,    1'b1, 2'b11, 1'b1, 1'b1, 1, EV_NONE, 1'b0));
        // Sync wait ends on the first tick with the pin high.
        plan.push_back(beat_row(KIND_SYNC,   1'b0, 2'b00, 1'b1, 1'b1, 1, EV_NONE, 1'b0));
        plan.push_back(beat_row(KIND_TICK,   1'b1, 2'b01, 1'b1, 1'b1, 1, EV_SYNC_OK, 1'b1));
        // Both waits open: ticks go to sync until it ends, then to detect.
        plan.push_back(beat_row(KIND_DETECT, 1'b0, 2'b00, 1'b0, 1'b0, 1, EV_NONE, 1'b0));
        plan.push_back(beat_row(KIND_SYNC,   1'b0, 2'b00, 1'b0, 1'b0, 1, EV_NONE, 1'b0));
        plan.push_back(beat_row(KIND_TICK,   1'b0, 2'b00, 1'b1, 1'b1, 1, EV_NONE, 1'b0));
        plan.push_back(beat_row(KIND_TICK,   1'b1, 2'b00, 1'b1, 1'b0, 1, EV_SYNC_OK, 1'b0));
        plan.push_back(beat_row(KIND_TICK,   1'b0, 2'b10, 1'b1, 1'b1, 0, EV_NONE, 1'b0));
        plan.push_back(beat_row(KIND_TICK,   1'b0, 2'b00, 1'b1, 1'b1, 0, EV_NONE, 1'b0));
        // Restart the detect wait while it is still open.
        plan.push_back(beat_row(KIND_DETECT, 1'b1, 2'b11, 1'b1, 1'b1, 1, EV_NONE, 1'b0));
        // Tight limits: zero wait, retry once, zero debounce, detect limit of one tick, zero warn threshold.
        plan.push_back(write_row(REG_MAX_WAIT,     20'd0));
        plan.push_back(write_row(REG_POLICY,       CFG_DATA_W'(POL_RETRY)));
        plan.push_back(write_row(REG_RETRY,        20'd1));
        plan.push_back(write_row(REG_DEBOUNCE,     20'd0));
        plan.push_back(write_row(REG_DETECT_LIMIT, 20'd1));
        plan.push_back(write_row(REG_WARN,         20'd0));
        plan.push_back(beat_row(KIND_SYNC,   1'b0, 2'b00, 1'b1, 1'b1, 1, EV_NONE, 1'b0));
        plan.push_back(beat_row(KIND_TICK,   1'b0, 2'b00, 1'b1, 1'b1, 1, EV_RETRY, 1'b0));
        plan.push_back(beat_row(KIND_TICK,   1'b0, 2'b00, 1'b1, 1'b1, 1, EV_PAUSE, 1'b0));
        // Detect confirms on the second quiet tick, then times out under chatter.
        plan.push_back(beat_row(KIND_DETECT, 1'b0, 2'b00, 1'b1, 1'b1, 1, EV_NONE, 1'b0));
        plan.push_back(beat_row(KIND_TICK,   1'b0, 2'b00, 1'b1, 1'b1, 1, EV_NONE, 1'b0));
        plan.push_back(beat_row(KIND_TICK,   1'b0, 2'b00, 1'b1, 1'b1, 1, EV_DETECT_OK, 1'b1));
        plan.push_back(beat_row(KIND_DETECT, 1'b0, 2'b00, 1'b1, 1'b1, 1, EV_NONE, 1'b0));
        plan.push_back(beat_row(KIND_TICK,   1'b0, 2'b01, 1'b1, 1'b1, 1, EV_NONE, 1'b0));
        plan.push_back(beat_row(KIND_TICK,   1'b0, 2'b10, 1'b0, 1'b1, 1, EV_DETECT_TIMEOUT,
                                1'b0));
        // Skip policy with a zero warn threshold always pauses.
        plan.push_back(write_row(REG_POLICY, CFG_DATA_W'(POL_SKIP)));
        plan.push_back(beat_row(KIND_SYNC,   1'b0, 2'b00, 1'b1, 1'b1, 1, EV_NONE, 1'b0));
        plan.push_back(beat_row(KIND_TICK,   1'b0, 2'b00, 1'b1, 1'b1, 1, EV_PAUSE, 1'b0));
        // Widest warn threshold: a plain skip that advances the queue.
        plan.push_back(write_row(REG_WARN, 20'hFFFF));
        plan.push_back(beat_row(KIND_SYNC,   1'b0, 2'b00, 1'b1, 1'b1, 1, EV_NONE, 1'b0));
        plan.push_back(beat_row(KIND_TICK,   1'b0, 2'b00, 1'b1, 1'b1, 1, EV_SYNC_SKIP, 1'b1));
        plan.push_back(write_row(REG_POLICY, CFG_DATA_W'(POL_ABORT)));
        plan.push_back(beat_row(KIND_SYNC,   1'b0, 2'b00, 1'b1, 1'b1, 1, EV_NONE, 1'b0));
        plan.push_back(beat_row(KIND_TICK,   1'b0, 2'b00, 1'b1, 1'b1, 1, EV_ABORT, 1'b0));

        foreach (plan[i]) begin
            row = plan[i];
            if (row.is_write) begin
                settle();
                write_reg(row.reg_index, row.reg_value);
            end else begin
                send(row.beat, row.typed, row.ev, row.adv);
            end
        end

        // Widest sync limit: run ticks with the pin low, no timeout may fire,
        // then close the wait with the pin high. Hold both sides busy.
        settle();
        write_reg(REG_MAX_WAIT, 20'hFFFFF);
        quiet <= 1'b1;
        send(rand_beat(KIND_SYNC));
        repeat (WIDE_LIMIT_TICKS) begin
            b      = rand_beat(KIND_TICK);
            b.sync = 1'b0;
            send(b);
        end
        b      = rand_beat(KIND_TICK);
        b.sync = 1'b1;
        send(b);
        quiet <= 1'b0;

        // Random phases, each under its own register setting; extremes in phases 1 and 3.
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                1:       next_cfg = '0;
                2:       next_cfg = random_cfg(POL_PAUSE);
                3:       next_cfg = '1;
                4:       next_cfg = random_cfg(POL_ABORT);
                5, 6:    next_cfg = random_cfg(POL_RETRY);
                default: next_cfg = random_cfg(POL_SKIP);
            endcase
            load_config(next_cfg);
            // Final phase runs with no idling on either side.
            if (phase == PHASES - 1)
                quiet <= 1'b1;
            random_phase(PHASE_BEATS);
        end

        settle();
        repeat (8) @(posedge aclk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/sdws_pkg.sv
hw/rtl/sdws_cfg_regs.sv
hw/rtl/sdws_engine.sv
hw/rtl/sync_detect_wait_supervisor_unit.sv
test/sync_detect_wait_supervisor_unit_test.sv
